[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int DEPTH       = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int OCC_WIDTH   = $clog2(DEPTH + 1);
  localparam int OP_WIDTH    = 3;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 11;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_FRONT      = 3'd6,
    OP_BACK       = 3'd7
  } deq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [2:0] {
    SH_NONE,
    SH_PUSH_FRONT,
    SH_PUSH_BACK,
    SH_POP_FRONT,
    SH_POP_BACK
  } deq_shift_t;

  // One cell as its neighbours see it: element counted from the front,
  // element counted from the back, and whether that position is occupied.
  typedef struct packed {
    logic                         valid;
    logic signed [DATA_WIDTH-1:0] fwd;
    logic signed [DATA_WIDTH-1:0] rev;
  } deq_view_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0]           op;
    logic signed [VALUE_WIDTH-1:0] value;
  } deq_req_t;

  typedef struct packed {
    deq_status_t                   status;
    logic signed [VALUE_WIDTH-1:0] data;
    logic [COUNT_WIDTH-1:0]        count;
    logic                          is_empty;
  } deq_rsp_t;

endpackage

[rtl/deq_cell.sv]
// One position of the queue, holding the front-ordered and back-ordered element.
module deq_cell
  import deq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  deq_shift_t                   shift,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  deq_view_t                    left,
  input  deq_view_t                    right,
  output deq_view_t                    view
);

  logic                         valid;
  logic signed [DATA_WIDTH-1:0] fwd;
  logic signed [DATA_WIDTH-1:0] rev;
  logic                         first_free;

  assign first_free = left.valid && !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (shift)
        SH_PUSH_FRONT, SH_PUSH_BACK: valid <= left.valid;
        SH_POP_FRONT, SH_POP_BACK:   valid <= right.valid;
        default:                     valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (shift)
      SH_PUSH_FRONT: begin
        fwd <= left.fwd;
        if (first_free) begin
          rev <= value;
        end
      end
      SH_PUSH_BACK: begin
        rev <= left.rev;
        if (first_free) begin
          fwd <= value;
        end
      end
      SH_POP_FRONT: fwd <= right.fwd;
      SH_POP_BACK:  rev <= right.rev;
      default: begin
      end
    endcase
  end

  assign view = '{valid: valid, fwd: fwd, rev: rev};

endmodule

[rtl/deq_chain.sv]
// Row of queue cells; cell 0 holds both the front and the back element.
module deq_chain
  import deq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  deq_shift_t                   shift,
  input  logic signed [DATA_WIDTH-1:0] value,
  output deq_view_t                    head
);

  deq_view_t views [DEPTH];
  deq_view_t in_edge;
  deq_view_t out_edge;

  assign in_edge  = '{valid: 1'b1, fwd: value, rev: value};
  assign out_edge = '{valid: 1'b0, fwd: '0, rev: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_view_t left;
    deq_view_t right;

    if (i == 0) begin : g_first
      assign left = in_edge;
    end else begin : g_inner_l
      assign left = views[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = out_edge;
    end else begin : g_inner_r
      assign right = views[i+1];
    end

    deq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .value (value),
      .left  (left),
      .right (right),
      .view  (views[i])
    );
  end

  assign head = views[0];

endmodule

[rtl/double_ended_queue.sv]
// Top level of the bounded double-ended queue.
//
//   channel | handshake            | word
//   --------+----------------------+---------------------------------------
//   req     | req_valid, req_stall | deq_req_t: op, value
//   rsp     | rsp_valid, rsp_stall | deq_rsp_t: status, data, count, is_empty
//
// One operation per cycle while req_stall is low: every cell shifts or writes in the same cycle,
// and both ends are read from cell 0, so no operation waits on the chain.
// A result (every operation but an accepted push gives one) appears in the cycle after its operation is taken.
// rst clears the occupancy, the cell valid chain and rsp_valid; the rsp word itself is not reset.
// req is held off only while a result sits in rsp under rsp_stall.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  deq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output deq_rsp_t rsp
);

  logic [OCC_WIDTH-1:0]         occupancy;
  logic [OCC_WIDTH-1:0]         occupancy_next;
  deq_shift_t                   shift;
  deq_view_t                    head;
  logic                         accept;
  logic                         full;
  logic                         empty;
  logic                         has_result;
  deq_status_t                  status;
  logic signed [DATA_WIDTH-1:0] elem;
  logic signed [DATA_WIDTH-1:0] store_value;

  assign req_stall   = rsp_valid && rsp_stall;
  assign accept      = req_valid && !req_stall;
  assign full        = occupancy == OCC_WIDTH'(DEPTH);
  assign empty       = occupancy == '0;
  assign store_value = DATA_WIDTH'(req.value);

  always_comb begin
    shift          = SH_NONE;
    has_result     = 1'b1;
    status         = ST_OK;
    elem           = '0;
    occupancy_next = occupancy;
    case (req.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          has_result     = 1'b0;
          shift          = (req.op == OP_PUSH_FRONT) ? SH_PUSH_FRONT : SH_PUSH_BACK;
          occupancy_next = occupancy + OCC_WIDTH'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_FRONT, OP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          elem = (req.op == OP_POP_FRONT || req.op == OP_FRONT) ? head.fwd : head.rev;
          if (req.op == OP_POP_FRONT) begin
            shift          = SH_POP_FRONT;
            occupancy_next = occupancy - OCC_WIDTH'(1);
          end else if (req.op == OP_POP_BACK) begin
            shift          = SH_POP_BACK;
            occupancy_next = occupancy - OCC_WIDTH'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  deq_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .shift (accept ? shift : SH_NONE),
    .value (store_value),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        occupancy <= occupancy_next;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept && has_result) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      rsp.status   <= status;
      rsp.data     <= VALUE_WIDTH'(elem);
      rsp.count    <= COUNT_WIDTH'(occupancy_next);
      rsp.is_empty <= occupancy_next == '0;
    end
  end

endmodule

[rtl/deq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker
  import deq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input deq_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.count == '0))
    else $error("is_empty disagrees with count");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |->
      rsp.count == COUNT_WIDTH'(DEPTH) && rsp.data == '0)
    else $error("full response with wrong count or data");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.is_empty && rsp.data == '0)
    else $error("empty response on a non-empty queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |-> rsp_valid && rsp_stall)
    else $error("request held off with no pending response");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

[bench/tb_double_ended_queue.sv]
// Self-checking bench for double_ended_queue: queued driver, clocked monitor, shadow deque.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_ITEMS  = 60;

  typedef struct {
    deq_req_t w;
    int       phase;
  } pend_t;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  deq_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  deq_rsp_t rsp;

  double_ended_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  pend_t       req_words[$];
  deq_rsp_t    rsp_expected[$];
  pend_t       next_word;
  logic signed [DATA_WIDTH-1:0] shadow_slots [DEPTH];
  int unsigned shadow_head;
  int unsigned shadow_count;

  int  total_words;
  int  sent_cnt;
  int  checked_cnt;
  int  err_cnt;
  int  full_hits;
  int  empty_hits;
  int  quiet;
  int  cur_phase;
  int  press_at;
  int  hold_left;
  bit  hold_done;
  logic req_fire;

  function automatic int send_idle_pct(input int ph);
    case (ph)
      1: return 66;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input int ph);
    case (ph)
      2: return 66;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7, 0))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_word(input deq_op_t op, input logic [31:0] v, input int ph);
    pend_t p;
    p.w.op    = op;
    p.w.value = v;
    p.phase   = ph;
    req_words.insert(req_words.size(), p);
  endtask

  // Shadow deque: head index plus occupancy over a ring of slots.
  function automatic void deque_apply(input deq_req_t w);
    deq_rsp_t    r;
    bit          gives;
    int unsigned idx;
    deq_op_t     op;
    op    = deq_op_t'(w.op);
    r     = '0;
    gives = 1'b1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          gives = 1'b0;
          if (op == OP_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_slots[shadow_head] = w.value;
            shadow_count++;
          end else begin
            shadow_count++;
            shadow_slots[(shadow_head + shadow_count - 1) % DEPTH] = w.value;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_FRONT, OP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          if (op == OP_POP_FRONT || op == OP_FRONT)
            idx = shadow_head;
          else
            idx = (shadow_head + shadow_count - 1) % DEPTH;
          r.data = shadow_slots[idx];
          if (op == OP_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_count--;
          end else if (op == OP_POP_BACK) begin
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    if (gives) begin
      r.count    = shadow_count[COUNT_WIDTH-1:0];
      r.is_empty = (shadow_count == 0);
      rsp_expected.insert(rsp_expected.size(), r);
    end
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    if (err_cnt < 30)
      $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked_cnt);
    err_cnt++;
  endtask

  task automatic check_result(input deq_rsp_t got);
    deq_rsp_t want;
    if (rsp_expected.size() == 0) begin
      report("unexpected word", got.status, -1);
    end else begin
      want = rsp_expected[0];
      rsp_expected.delete(0);
      if (got.status !== want.status)     report("status", got.status, want.status);
      if (got.data !== want.data)         report("data", got.data, want.data);
      if (got.count !== want.count)       report("count", got.count, want.count);
      if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
    end
    checked_cnt++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (req_words.size() != 0 &&
          $urandom_range(99, 0) >= send_idle_pct(req_words[0].phase)) begin
        next_word = req_words[0];
        req_words.delete(0);
        req       <= next_word.w;
        cur_phase <= next_word.phase;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && sent_cnt >= press_at) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst)
      rsp_stall <= 1'b0;
    else if (hold_left != 0)
      rsp_stall <= 1'b1;
    else
      rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct(cur_phase));
  end

  // monitor
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall)
        check_result(rsp);
      if (req_valid && !req_stall) begin
        deque_apply(req);
        sent_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               quiet, rsp_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int burst;
    int mode;
    int k;
    deq_op_t op;

    rst          = 1'b1;
    req_valid    = 1'b0;
    rsp_stall    = 1'b0;
    req          = '0;
    req_fire     = 1'b0;
    shadow_head  = 0;
    shadow_count = 0;
    sent_cnt     = 0;
    checked_cnt  = 0;
    err_cnt      = 0;
    full_hits    = 0;
    empty_hits   = 0;
    quiet        = 0;
    cur_phase    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;

    // empty queue, extremes, head wrap below zero
    add_word(OP_POP_FRONT,  32'h0, 0);
    add_word(OP_POP_BACK,   32'h0, 0);
    add_word(OP_FRONT,      32'h0, 0);
    add_word(OP_BACK,       32'h0, 0);
    add_word(OP_SIZE,       32'h0, 0);
    add_word(OP_EMPTY,      32'h0, 0);
    add_word(OP_PUSH_FRONT, 32'h7fff_ffff, 0);
    add_word(OP_PUSH_BACK,  32'h8000_0000, 0);
    add_word(OP_PUSH_FRONT, 32'hffff_ffff, 0);
    add_word(OP_PUSH_BACK,  32'h0000_0000, 0);
    add_word(OP_SIZE,       32'h0, 0);
    add_word(OP_EMPTY,      32'h0, 0);
    add_word(OP_FRONT,      32'h0, 0);
    add_word(OP_BACK,       32'h0, 0);
    add_word(OP_POP_BACK,   32'h0, 0);
    add_word(OP_POP_FRONT,  32'h0, 0);
    add_word(OP_FRONT,      32'h0, 0);
    add_word(OP_BACK,       32'h0, 0);
    add_word(OP_POP_FRONT,  32'h0, 0);
    add_word(OP_POP_BACK,   32'h0, 0);
    add_word(OP_POP_BACK,   32'h0, 0);
    add_word(OP_EMPTY,      32'h0, 0);

    // fill to the brim, then push into a full queue
    k = 0;
    for (n = 0; n < DEPTH; n++) begin
      add_word(n[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(), (k / 128) % 4);
      k++;
    end
    add_word(OP_PUSH_FRONT, pick_value(), 0);
    add_word(OP_PUSH_BACK,  pick_value(), 0);
    add_word(OP_SIZE,       32'h0, 0);
    add_word(OP_FRONT,      32'h0, 0);
    add_word(OP_BACK,       32'h0, 0);

    press_at = req_words.size() + 5;

    // bursts that grow, shrink or churn the queue
    n = 0;
    while (n < RAND_ITEMS) begin
      burst = $urandom_range(40, 5);
      mode  = $urandom_range(2, 0);
      repeat (burst) begin
        if (mode == 0 && $urandom_range(3, 0) != 0)
          op = $urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (mode == 1 && $urandom_range(3, 0) != 0)
          case ($urandom_range(3, 0))
            0: op = OP_POP_FRONT;
            1: op = OP_POP_BACK;
            2: op = OP_FRONT;
            default: op = OP_BACK;
          endcase
        else
          op = deq_op_t'($urandom_range(7, 0));
        add_word(op, pick_value(), (n / 15) % 4);
        n++;
      end
    end
    total_words = req_words.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (sent_cnt < total_words) @(negedge clk);
    while (rsp_expected.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (rsp_expected.size() != 0)
      report("results left over", rsp_expected.size(), 0);

    $display("ran %0d operations with a fill to full and random bursts, %0d results checked",
             sent_cnt, checked_cnt);
    $display("%0d full-drop and %0d empty results, %0d mismatches",
             full_hits, empty_hits, err_cnt);
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
